### rtl/ahum_pkg.sv
// Shared constants and widths for the absolute humidity core.
package ahum_pkg;

  localparam int unsigned T_W      = 15;
  localparam int unsigned RH_W     = 17;
  localparam int unsigned OUT_W    = 19;
  localparam int unsigned DEN_W    = 16;
  localparam int unsigned NUM1_W   = 44;
  localparam int unsigned Y_W      = 30;
  localparam int unsigned YP_W     = 31;
  localparam int unsigned FRAC_W   = 24;
  localparam int unsigned KB_W     = 7;
  localparam int unsigned MANT_W   = 32;
  localparam int unsigned M20_W    = 22;
  localparam int unsigned P_W      = 39;
  localparam int unsigned NUM2_W   = 58;
  localparam int unsigned Q2_W     = 45;
  localparam int unsigned SCALE_W  = 19;
  localparam int unsigned COEF_W   = 29;

  localparam int unsigned EXP_SEGMENTS_DEF = 64;

  localparam logic [DEN_W:0]    D_OFFSET   = 17'd24312;
  localparam logic [DEN_W:0]    E_OFFSET   = 17'd27315;
  localparam logic [COEF_W-1:0] LOG2E_COEF = 29'd426481639;
  localparam logic [63:0]       LN2_Q30    = 64'd744261118;
  localparam logic [63:0]       ONE_Q30    = 64'd1073741824;
  localparam int unsigned       TAYLOR_N   = 20;
  localparam logic [SCALE_W-1:0] SCALE_Q8  = 19'd331118;
  localparam logic [OUT_W-1:0]  OUT_MAX    = 19'd524287;
  localparam logic [YP_W-1:0]   YP_BIAS    = 31'h4000_0000;
  localparam logic [7:0]        SHIFT_BASE = 8'd92;

endpackage

### rtl/ahum_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
module ahum_div #(
  parameter int unsigned NUM_W  = 44,
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned Q_W    = 30,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [Q_W-1:0]    quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              vld_q  [Q_W];
  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [Q_W-1:0]    work_q [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [Q_W-1:0]    work_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              qbit;

    if (s == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = DEN_W'(num_i >> Q_W);
      assign work_in = num_i[Q_W-1:0];
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign work_in = work_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    assign trial = {rem_in, work_in[Q_W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign qbit  = ~diff[DEN_W];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        work_q[s] <= {work_in[Q_W-2:0], qbit};
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[Q_W-1];
  assign quo_o   = work_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

### rtl/absolute_humidity_from_rh_temp_core.sv
// Absolute humidity from temperature and relative humidity, Magnus formula.
//
// Input channel: in_valid_i / in_ready_o with temperature_centi_i (signed,
// 0.01 C) and rel_humidity_i (1/1024 percent). Output channel:
// out_valid_o / out_ready_i with abs_humidity_mg_o (mg/m3, saturating).
// One result per input transaction, in order.
//
// Pipeline: two input stages, a 30-stage exponent divider, eight stages
// for the 2^f table interpolation and scaling multiplies, a 45-stage
// quotient divider and the output register. One transaction per cycle
// unless the receiver stalls; the two bit-per-stage dividers set depth.
//
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver stalls with a result waiting, the whole pipeline
// holds and in_ready_o drops; nothing is lost or repeated.
module absolute_humidity_from_rh_temp_core
  import ahum_pkg::*;
#(
  parameter int unsigned EXP_SEGMENTS = EXP_SEGMENTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic signed [T_W-1:0]  temperature_centi_i,
  input  logic [RH_W-1:0]        rel_humidity_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_W-1:0]       abs_humidity_mg_o
);

  localparam int unsigned IDX_W  = $clog2(EXP_SEGMENTS + 1);
  localparam int unsigned POS_W  = FRAC_W + IDX_W;
  localparam int unsigned SIDE1_W = 1 + DEN_W + RH_W;

  function automatic logic [MANT_W-1:0] pow2_rom(input int unsigned idx);
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    z = (64'(idx) * LN2_Q30 + 64'(EXP_SEGMENTS / 2)) / 64'(EXP_SEGMENTS);
    sum  = ONE_Q30;
    term = ONE_Q30;
    for (int unsigned n = 1; n <= TAYLOR_N; n++) begin
      term = ((term * z) >> 30) / 64'(n);
      sum  = sum + term;
    end
    return sum[MANT_W-1:0];
  endfunction

  logic [MANT_W-1:0] rom [EXP_SEGMENTS+1];
  for (genvar i = 0; i <= EXP_SEGMENTS; i++) begin : g_rom
    assign rom[i] = pow2_rom(i);
  end

  logic en;
  logic out_valid_q;
  logic [OUT_W-1:0] out_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign abs_humidity_mg_o = out_q;

  // stage 0: offsets and magnitude
  logic [DEN_W:0] d_full, e_full;
  logic [T_W-1:0] t_u;
  assign t_u    = T_W'(temperature_centi_i);
  assign d_full = D_OFFSET + {{2{t_u[T_W-1]}}, t_u};
  assign e_full = E_OFFSET + {{2{t_u[T_W-1]}}, t_u};

  logic v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q;
  logic             neg0_q;
  logic [T_W-1:0]   tmag0_q;
  logic [DEN_W-1:0] d0_q, e0_q;
  logic [RH_W-1:0]  rh0_q;

  logic [NUM1_W-1:0] num1_q;
  logic [DEN_W-1:0]  d1_q;
  logic [SIDE1_W-1:0] side1_q;

  logic               dv1_v;
  logic [Y_W-1:0]     ymag;
  logic [SIDE1_W-1:0] dv1_side;

  logic [YP_W-1:0]  yp2_q;
  logic [DEN_W-1:0] e2_q, e3_q, e4_q, e5_q, e6_q, e7_q, e8_q, e9_q;
  logic [RH_W-1:0]  rh2_q, rh3_q, rh4_q, rh5_q, rh6_q;
  logic [KB_W-1:0]  kb3_q, kb4_q, kb5_q, kb6_q, kb7_q, kb8_q, kb9_q;
  logic [IDX_W-1:0] seg3_q;
  logic [FRAC_W-1:0] r3_q, r4_q;
  logic [MANT_W-1:0] lo4_q, hi4_q, base5_q;
  logic [MANT_W+FRAC_W-1:0] prod5_q;
  logic [M20_W-1:0] m20_6_q;
  logic [P_W-1:0]   p7_q;
  logic [P_W-1:0]   plo8_q;
  logic [P_W-2:0]   phi8_q;
  logic [NUM2_W-1:0] num9_q;

  logic             dv2_v;
  logic [Q2_W-1:0]  quo;
  logic [KB_W-1:0]  dv2_kb;

  logic [POS_W-1:0]  pos;
  logic [MANT_W-1:0] dlt;
  logic [MANT_W-1:0] mant;
  logic [7:0]        shamt;
  logic [Q2_W-1:0]   qs;
  logic [OUT_W-1:0]  res;

  assign pos  = POS_W'(yp2_q[FRAC_W-1:0]) * POS_W'(EXP_SEGMENTS);
  assign dlt  = (hi4_q >= lo4_q) ? (hi4_q - lo4_q) : '0;
  assign mant = base5_q + MANT_W'(prod5_q >> FRAC_W);

  always_comb begin
    shamt = SHIFT_BASE - 8'(dv2_kb);
    qs    = quo >> shamt[5:0];
    if (shamt[7]) begin
      res = (quo != '0) ? OUT_MAX : '0;
    end else if (shamt[6]) begin
      res = '0;
    end else if (qs > Q2_W'(OUT_MAX)) begin
      res = OUT_MAX;
    end else begin
      res = qs[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0; v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0; v9_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= dv1_v;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
      v9_q <= v8_q;
      out_valid_q <= dv2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg0_q  <= t_u[T_W-1];
      tmag0_q <= t_u[T_W-1] ? (~t_u + T_W'(1)) : t_u;
      d0_q    <= d_full[DEN_W-1:0];
      e0_q    <= e_full[DEN_W-1:0];
      rh0_q   <= rel_humidity_i;

      num1_q  <= NUM1_W'(tmag0_q) * NUM1_W'(LOG2E_COEF) + NUM1_W'(d0_q >> 1);
      d1_q    <= d0_q;
      side1_q <= {neg0_q, e0_q, rh0_q};

      yp2_q <= dv1_side[SIDE1_W-1] ? (YP_BIAS - YP_W'(ymag)) : (YP_BIAS + YP_W'(ymag));
      e2_q  <= dv1_side[RH_W +: DEN_W];
      rh2_q <= dv1_side[RH_W-1:0];

      seg3_q <= pos[POS_W-1:FRAC_W];
      r3_q   <= pos[FRAC_W-1:0];
      kb3_q  <= yp2_q[YP_W-1:FRAC_W];
      e3_q   <= e2_q;
      rh3_q  <= rh2_q;

      lo4_q <= rom[seg3_q];
      hi4_q <= rom[seg3_q + IDX_W'(1)];
      r4_q  <= r3_q;
      kb4_q <= kb3_q;
      e4_q  <= e3_q;
      rh4_q <= rh3_q;

      prod5_q <= (MANT_W+FRAC_W)'(dlt) * (MANT_W+FRAC_W)'(r4_q);
      base5_q <= lo4_q;
      kb5_q   <= kb4_q;
      e5_q    <= e4_q;
      rh5_q   <= rh4_q;

      m20_6_q <= mant[MANT_W-1:MANT_W-M20_W];
      kb6_q   <= kb5_q;
      e6_q    <= e5_q;
      rh6_q   <= rh5_q;

      p7_q  <= P_W'(rh6_q) * P_W'(m20_6_q);
      kb7_q <= kb6_q;
      e7_q  <= e6_q;

      plo8_q <= P_W'(p7_q[19:0]) * P_W'(SCALE_Q8);
      phi8_q <= (P_W-1)'(p7_q[P_W-1:20]) * (P_W-1)'(SCALE_Q8);
      kb8_q  <= kb7_q;
      e8_q   <= e7_q;

      num9_q <= (NUM2_W'(phi8_q) << 20) + NUM2_W'(plo8_q);
      kb9_q  <= kb8_q;
      e9_q   <= e8_q;

      out_q <= res;
    end
  end

  ahum_div #(
    .NUM_W (NUM1_W),
    .DEN_W (DEN_W),
    .Q_W   (Y_W),
    .SIDE_W(SIDE1_W)
  ) u_div_exp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v1_q),
    .num_i  (num1_q),
    .den_i  (d1_q),
    .side_i (side1_q),
    .valid_o(dv1_v),
    .quo_o  (ymag),
    .side_o (dv1_side)
  );

  ahum_div #(
    .NUM_W (NUM2_W),
    .DEN_W (DEN_W),
    .Q_W   (Q2_W),
    .SIDE_W(KB_W)
  ) u_div_quo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v9_q),
    .num_i  (num9_q),
    .den_i  (e9_q),
    .side_i (kb9_q),
    .valid_o(dv2_v),
    .quo_o  (quo),
    .side_o (dv2_kb)
  );

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({v0_q, v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q}))
    else $error("pipeline valid bits moved during stall");

  a_exp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (kb3_q >= KB_W'(11)) && (kb3_q <= KB_W'(75)))
    else $error("exponent out of range");

  a_rom_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> hi4_q >= lo4_q)
    else $error("table segment not increasing");

endmodule

### test/tb_absolute_humidity_from_rh_temp_core.sv
// Testbench for the absolute humidity core: directed and random samples, scoreboard check.
`timescale 1ns / 100ps
module tb_absolute_humidity_from_rh_temp_core;
  import ahum_pkg::*;

  localparam int unsigned SEGS = EXP_SEGMENTS_DEF;
  localparam int N_RANDOM = 850;

  typedef struct packed {
    logic signed [T_W-1:0] temp;
    logic [RH_W-1:0]       rh;
  } sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [T_W-1:0] temperature_centi_i = '0;
  logic [RH_W-1:0] rel_humidity_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [OUT_W-1:0] abs_humidity_mg_o;

  absolute_humidity_from_rh_temp_core #(.EXP_SEGMENTS(SEGS)) uut (.*);

  always #10 clk_i = ~clk_i;

  sample_t pending_q[$];
  logic [OUT_W-1:0] humidity_q[$];
  int errors = 0;
  int checked = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_phase = 0;
  bit in_taken = 1'b0;

  function automatic logic [63:0] pow2_entry(input logic [63:0] i);
    logic [63:0] z, sum, term;
    z = (i * LN2_Q30 + 64'(SEGS / 2)) / 64'(SEGS);
    sum = ONE_Q30;
    term = ONE_Q30;
    for (int n = 1; n <= TAYLOR_N; n++) begin
      term = ((term * z) >> 30) / 64'(n);
      sum += term;
    end
    return sum;
  endfunction

  function automatic logic [OUT_W-1:0] magnus_humidity(input sample_t s);
    int t, k, sh;
    logic [63:0] d, e, tmag, ymag, yp, f, pos, seg, r, e0, e1, mant, q, res;
    t = s.temp;
    d = 64'(24312 + t);
    e = 64'(27315 + t);
    tmag = 64'(t < 0 ? -t : t);
    ymag = (tmag * 64'd426481639 + d / 2) / d;
    yp = (t < 0) ? ((64'd64 << 24) - ymag) : ((64'd64 << 24) + ymag);
    k = int'(yp >> 24) - 64;
    f = yp & 64'hFFFFFF;
    pos = f * 64'(SEGS);
    seg = pos >> 24;
    r = pos & 64'hFFFFFF;
    e0 = pow2_entry(seg);
    e1 = pow2_entry(seg + 1);
    mant = e0 + ((e1 >= e0) ? (((e1 - e0) * r) >> 24) : 64'd0);
    q = (64'(s.rh) * (mant >> 10) * 64'd331118) / e;
    sh = 28 - k;
    if (sh < 0) res = (q != 0) ? 64'(OUT_MAX) : 64'd0;
    else if (sh >= 64) res = 0;
    else res = q >> sh;
    if (res > 64'(OUT_MAX)) res = 64'(OUT_MAX);
    return res[OUT_W-1:0];
  endfunction

  function automatic sample_t mk(input int t, input int rh);
    sample_t s;
    s.temp = T_W'(t);
    s.rh = RH_W'(rh);
    return s;
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (in_valid_i) void'(pending_q.pop_front());
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          sample_t nx;
          nx = pending_q[0];
          in_valid_i <= 1'b1;
          temperature_centi_i <= nx.temp;
          rel_humidity_i <= nx.rh;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      stall_phase = (stall_phase + 1) % 97;
      out_ready_i <= (stall_phase < 40) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end
  end

  // predictor hook at input transaction, check at output transaction
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken)
      humidity_q.push_back(magnus_humidity(mk(temperature_centi_i, rel_humidity_i)));
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (humidity_q.size() == 0) begin
        $display("%0t: unexpected result, actual %0d", $time, abs_humidity_mg_o);
        errors++;
      end else begin
        logic [OUT_W-1:0] exp_v;
        exp_v = humidity_q.pop_front();
        checked++;
        if (exp_v !== abs_humidity_mg_o) begin
          $display("%0t: mismatch, expected %0d actual %0d", $time, exp_v, abs_humidity_mg_o);
          errors++;
        end
      end
    end
  end

  initial begin
    int tv[] = '{-4000, 8500, 0, -16384, 16383, -1, 1, 2500, -12000, 15000};
    int rv[] = '{0, 102400, 131071, 1, 65536, 51200};
    int wait_cycles;
    foreach (tv[i]) pending_q.push_back(mk(tv[i], rv[i % 6]));
    pending_q.push_back(mk(16383, 131071));
    pending_q.push_back(mk(-16384, 131071));
    pending_q.push_back(mk(8500, 0));
    pending_q.push_back(mk(-16384, 0));
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 3))
        0: pending_q.push_back(mk($urandom_range(0, 32767) - 16384, $urandom_range(0, 131071)));
        default: pending_q.push_back(mk($urandom_range(0, 12500) - 4000,
                                        $urandom_range(0, 102400)));
      endcase
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    while (pending_q.size() != 0 || humidity_q.size() != 0) @(posedge clk_i);
    wait_cycles = 0;
    while (wait_cycles < 200) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    $display("Checked %0d results over directed extremes and random samples.", checked);
    if (errors == 0 && humidity_q.size() == 0) $display("tb_absolute_humidity_from_rh_temp_core: PASS");
    else $display("tb_absolute_humidity_from_rh_temp_core: FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_absolute_humidity_from_rh_temp_core: FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/ahum_pkg.sv
rtl/ahum_div.sv
rtl/absolute_humidity_from_rh_temp_core.sv
test/tb_absolute_humidity_from_rh_temp_core.sv
